// File: hdl/paik_pkg.sv
// ---------------------------------------------------------------------------
// Planar arm solver package
// Shared constants, command codes and the CORDIC arctangent table.
// ---------------------------------------------------------------------------
package paik_pkg;

  localparam int DEF_MAX_JOINTS = 8;
  localparam int DEF_ANGLE_BITS = 16;
  localparam int DEF_COORD_BITS = 24;

  localparam int CORDIC_STEPS = 30;
  localparam logic [31:0] CORDIC_GAIN_INV = 32'd652032874;

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_SOLVE = 1'b1;

  function automatic logic [31:0] cordic_atan(input logic [4:0] idx);
    logic [31:0] r;
    unique case (idx)
      5'd0:  r = 32'h20000000;
      5'd1:  r = 32'h12E4051E;
      5'd2:  r = 32'h09FB385B;
      5'd3:  r = 32'h051111D4;
      5'd4:  r = 32'h028B0D43;
      5'd5:  r = 32'h0145D7E1;
      5'd6:  r = 32'h00A2F61E;
      5'd7:  r = 32'h00517C55;
      5'd8:  r = 32'h0028BE53;
      5'd9:  r = 32'h00145F2F;
      5'd10: r = 32'h000A2F98;
      5'd11: r = 32'h000517CC;
      5'd12: r = 32'h00028BE6;
      5'd13: r = 32'h000145F3;
      5'd14: r = 32'h0000A2FA;
      5'd15: r = 32'h0000517D;
      5'd16: r = 32'h000028BE;
      5'd17: r = 32'h0000145F;
      5'd18: r = 32'h00000A30;
      5'd19: r = 32'h00000518;
      5'd20: r = 32'h0000028C;
      5'd21: r = 32'h00000146;
      5'd22: r = 32'h000000A3;
      5'd23: r = 32'h00000051;
      5'd24: r = 32'h00000029;
      5'd25: r = 32'h00000014;
      5'd26: r = 32'h0000000A;
      5'd27: r = 32'h00000005;
      5'd28: r = 32'h00000003;
      5'd29: r = 32'h00000001;
      default: r = 32'h00000000;
    endcase
    return r;
  endfunction

endpackage

// File: hdl/planar_arm_ccd_ik_solver.sv
// ---------------------------------------------------------------------------
// Planar arm solver by cyclic coordinate descent
// Joint state in one synchronous memory, one shared iterative CORDIC unit.
// ---------------------------------------------------------------------------
// A load item reads the joint entry and writes it back with the new link length. The CORDIC runs set the pace.
// Results of a solve come one per cycle, the last one in the same cycle that busy falls.
// One item is worked on at a time.
// Reset clears all joint state, the tip and sets the joint count to two.
module planar_arm_ccd_ik_solver #(
  parameter int MAX_JOINTS = paik_pkg::DEF_MAX_JOINTS,
  parameter int ANGLE_BITS = paik_pkg::DEF_ANGLE_BITS,
  parameter int COORD_BITS = paik_pkg::DEF_COORD_BITS
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [3:0]                   cfg_wdata_i,
  input  logic                         start,
  output logic                         busy,
  input  logic                         command_i,
  input  logic [2:0]                   joint_index_i,
  input  logic [15:0]                  link_length_i,
  input  logic signed [COORD_BITS-1:0] target_x_i,
  input  logic signed [COORD_BITS-1:0] target_y_i,
  input  logic [7:0]                   iterations_i,
  output logic                         strobe_o,
  output logic [2:0]                   joint_number_o,
  output logic signed [ANGLE_BITS-1:0] local_angle_o,
  output logic signed [COORD_BITS-1:0] joint_x_o,
  output logic signed [COORD_BITS-1:0] joint_y_o,
  output logic                         last_o
);
  import paik_pkg::*;

  localparam int A  = ANGLE_BITS;
  localparam int C  = COORD_BITS;
  localparam int AW = (MAX_JOINTS > 1) ? $clog2(MAX_JOINTS) : 1;
  localparam int VW = C + 24;
  localparam int PW = C + 31;
  localparam int LEN_LO = 0;
  localparam int LOC_LO = 16;
  localparam int GLB_LO = 16 + A;
  localparam int X_LO   = 16 + 2 * A;
  localparam int Y_LO   = 16 + 2 * A + C;
  localparam int EW     = 16 + 2 * A + 2 * C;

  typedef enum logic [20:0] {
    S_IDLE   = 21'(1) << 0,
    S_LD_R   = 21'(1) << 1,
    S_LD_W   = 21'(1) << 2,
    S_AL_R1  = 21'(1) << 3,
    S_AL_R2  = 21'(1) << 4,
    S_AL_CW  = 21'(1) << 5,
    S_FK_R0  = 21'(1) << 6,
    S_FK_R1  = 21'(1) << 7,
    S_FK_M   = 21'(1) << 8,
    S_FK_CW  = 21'(1) << 9,
    S_FK_MX  = 21'(1) << 10,
    S_FK_MY  = 21'(1) << 11,
    S_UP_R1  = 21'(1) << 12,
    S_UP_R2  = 21'(1) << 13,
    S_UP_CW1 = 21'(1) << 14,
    S_UP_CW2 = 21'(1) << 15,
    S_RT     = 21'(1) << 16,
    S_RT_CW1 = 21'(1) << 17,
    S_RT_CW2 = 21'(1) << 18,
    S_OUT_R  = 21'(1) << 19,
    S_OUT_E  = 21'(1) << 20
  } state_e;

  typedef enum logic [3:0] {
    PH_PASS_FK1 = 4'b0001,
    PH_INNER_FK = 4'b0010,
    PH_PASS_FK0 = 4'b0100,
    PH_FINAL_FK = 4'b1000
  } phase_e;

  state_e state_q, state_d;
  phase_e ph_q, ph_d;

  logic [3:0]   joint_count_q;
  logic         fin_q, fin_d;
  logic         first_q, first_d;
  logic [AW:0]  n_q, n_d;
  logic [AW-1:0] k_q, k_d, i_q, i_d, j_q, j_d;
  logic [A-1:0] gp_q, gp_d, cur_q, cur_d;
  logic [EW-1:0] e_q, e_d;
  logic [C-1:0] px_q, px_d, py_q, py_d, tipx_q, tipx_d, tipy_q, tipy_d;
  logic [C-1:0] tx_q, tx_d, ty_q, ty_d;
  logic [7:0]   iters_q, iters_d, pass_q, pass_d;
  logic [15:0]  ld_len_q, ld_len_d;
  logic signed [PW-1:0] prod_q, prod_d;

  // Joint memory with valid bits standing in for the reset value.
  logic [EW-1:0] mem [MAX_JOINTS];
  logic [MAX_JOINTS-1:0] val_q;
  logic [EW-1:0] rdata_q;
  logic          rval_q;
  logic          re, we;
  logic [AW-1:0] ra, wa;
  logic [EW-1:0] wd, rent;

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (re) begin
      rdata_q <= mem[ra];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      val_q  <= '0;
      rval_q <= 1'b0;
    end else begin
      if (we) begin
        val_q[wa] <= 1'b1;
      end
      if (re) begin
        rval_q <= val_q[ra];
      end
    end
  end

  assign rent = rval_q ? rdata_q : '0;

  logic [A-1:0] r_loc, r_glb;
  logic [C-1:0] r_x, r_y;
  assign r_loc = rent[LOC_LO +: A];
  assign r_glb = rent[GLB_LO +: A];
  assign r_x   = rent[X_LO +: C];
  assign r_y   = rent[Y_LO +: C];

  // Shared CORDIC unit: rotation for sine and cosine, vectoring for the aim angle.
  logic                 cd_start, cd_rot;
  logic [A-1:0]         cd_ang;
  logic signed [C:0]    cd_ax, cd_ay;
  logic signed [VW-1:0] cx_q, cy_q;
  logic signed [33:0]   cz_q;
  logic [4:0]           cstep_q;
  logic                 crun_q, cdone_q, crot_q, cneg_q, czero_q;
  logic [31:0]          cbase_q;

  logic signed [VW-1:0] ci_x, ci_y, sx, sy;
  logic signed [33:0]   ci_z, ct;
  logic [31:0]          a32, ci_base;
  logic                 ci_neg, pdir;

  always_comb begin
    a32     = {cd_ang, (32 - A)'(0)};
    ci_neg  = 1'b0;
    ci_base = '0;
    if (cd_rot) begin
      ci_x = VW'($signed({1'b0, CORDIC_GAIN_INV}));
      ci_y = '0;
      ci_z = {{2{a32[31]}}, a32};
      if (ci_z > 34'sd1073741824) begin
        ci_z   = ci_z - 34'sd2147483648;
        ci_neg = 1'b1;
      end else if (ci_z < -34'sd1073741824) begin
        ci_z   = ci_z + 34'sd2147483648;
        ci_neg = 1'b1;
      end
    end else begin
      ci_x = VW'(cd_ay) <<< 20;
      ci_y = VW'(cd_ax) <<< 20;
      ci_z = '0;
      if (ci_x < 0) begin
        ci_x    = -ci_x;
        ci_y    = -ci_y;
        ci_base = 32'h80000000;
      end
    end
  end

  always_comb begin
    sx   = cy_q >>> cstep_q;
    sy   = cx_q >>> cstep_q;
    ct   = {2'b00, cordic_atan(cstep_q)};
    pdir = crot_q ? !cz_q[33] : (cy_q <= 0);
  end

  always_ff @(posedge clk_i) begin
    if (cd_start) begin
      cx_q    <= ci_x;
      cy_q    <= ci_y;
      cz_q    <= ci_z;
      crot_q  <= cd_rot;
      cneg_q  <= ci_neg;
      cbase_q <= ci_base;
      czero_q <= !cd_rot && (cd_ax == 0) && (cd_ay == 0);
    end else if (crun_q) begin
      if (pdir) begin
        cx_q <= cx_q - sx;
        cy_q <= cy_q + sy;
        cz_q <= cz_q - ct;
      end else begin
        cx_q <= cx_q + sx;
        cy_q <= cy_q - sy;
        cz_q <= cz_q + ct;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crun_q  <= 1'b0;
      cdone_q <= 1'b0;
      cstep_q <= '0;
    end else if (cd_start) begin
      crun_q  <= 1'b1;
      cdone_q <= 1'b0;
      cstep_q <= '0;
    end else if (crun_q) begin
      cstep_q <= cstep_q + 5'd1;
      if (cstep_q == 5'(CORDIC_STEPS - 1)) begin
        crun_q  <= 1'b0;
        cdone_q <= 1'b1;
      end
    end
  end

  logic [31:0]          ang_r, ang_rr;
  logic [A-1:0]         ang;
  logic signed [VW-1:0] s_full, c_full;
  logic signed [32:0]   s33, c33;
  always_comb begin
    ang_r  = cbase_q + cz_q[31:0];
    ang_rr = ang_r + (32'd1 << (31 - A));
    ang    = czero_q ? '0 : ang_rr[31 -: A];
    s_full = cneg_q ? -cy_q : cy_q;
    c_full = cneg_q ? -cx_q : cx_q;
    s33    = s_full[32:0];
    c33    = c_full[32:0];
  end

  function automatic logic [C-1:0] rnd_off(input logic signed [PW-1:0] p);
    logic signed [PW-1:0] t;
    t = p + (PW'(1) << 29);
    return t[30 +: C];
  endfunction

  logic signed [16:0] mul_a;
  logic signed [32:0] mul_b;
  assign mul_a = $signed({1'b0, e_q[LEN_LO +: 16]});
  assign mul_b = (state_q == S_FK_CW) ? s33 : c33;

  logic [31:0]   nc;
  logic [AW:0]   nm1, nm2;
  logic [A-1:0]  g_calc;
  logic [EW-1:0] ent;
  logic [C-1:0]  py_new;

  assign nm1 = n_q - (AW + 1)'(1);
  assign nm2 = n_q - (AW + 1)'(2);

  logic       out_stb_d, out_last_d;
  logic [2:0] out_num_d;
  logic [31:0] jw;
  assign jw = 32'(j_q);

  always_comb begin
    state_d  = state_q;
    ph_d     = ph_q;
    fin_d    = fin_q;
    first_d  = first_q;
    n_d      = n_q;
    k_d      = k_q;
    i_d      = i_q;
    j_d      = j_q;
    gp_d     = gp_q;
    cur_d    = cur_q;
    e_d      = e_q;
    px_d     = px_q;
    py_d     = py_q;
    tipx_d   = tipx_q;
    tipy_d   = tipy_q;
    tx_d     = tx_q;
    ty_d     = ty_q;
    iters_d  = iters_q;
    pass_d   = pass_q;
    ld_len_d = ld_len_q;
    prod_d   = prod_q;
    re       = 1'b0;
    ra       = '0;
    we       = 1'b0;
    wa       = '0;
    wd       = rent;
    cd_start = 1'b0;
    cd_rot   = 1'b0;
    cd_ang   = '0;
    cd_ax    = '0;
    cd_ay    = '0;
    g_calc   = '0;
    ent      = rent;
    py_new   = '0;
    nc       = 32'(joint_count_q);
    out_stb_d  = 1'b0;
    out_last_d = 1'b0;
    out_num_d  = jw[2:0];

    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          if (command_i == CMD_LOAD) begin
            ld_len_d = link_length_i;
            k_d      = AW'(32'(joint_index_i));
            if (32'(joint_index_i) < 32'(MAX_JOINTS)) begin
              state_d = S_LD_R;
            end
          end else begin
            if (nc < 32'd2) begin
              nc = 32'd2;
            end else if (nc > 32'(MAX_JOINTS)) begin
              nc = 32'(MAX_JOINTS);
            end
            n_d     = (AW + 1)'(nc);
            tx_d    = target_x_i;
            ty_d    = target_y_i;
            iters_d = iterations_i;
            pass_d  = '0;
            fin_d   = 1'b0;
            if (iterations_i == 8'd0) begin
              k_d     = '0;
              ph_d    = PH_FINAL_FK;
              state_d = S_FK_R0;
            end else begin
              state_d = S_AL_R1;
            end
          end
        end
      end
      S_LD_R: begin
        re      = 1'b1;
        ra      = k_q;
        state_d = S_LD_W;
      end
      S_LD_W: begin
        we      = 1'b1;
        wa      = k_q;
        wd      = rent;
        wd[LEN_LO +: 16] = ld_len_q;
        state_d = S_IDLE;
      end
      S_AL_R1: begin
        re      = 1'b1;
        ra      = nm1[AW-1:0];
        state_d = S_AL_R2;
      end
      S_AL_R2: begin
        e_d      = rent;
        re       = 1'b1;
        ra       = nm2[AW-1:0];
        cd_start = 1'b1;
        cd_ax    = $signed({tx_q[C-1], tx_q}) - $signed({r_x[C-1], r_x});
        cd_ay    = $signed({ty_q[C-1], ty_q}) - $signed({r_y[C-1], r_y});
        state_d  = S_AL_CW;
      end
      S_AL_CW: begin
        if (cdone_q) begin
          we = 1'b1;
          wa = nm1[AW-1:0];
          wd = e_q;
          wd[LOC_LO +: A] = ang - r_glb;
          if (fin_q) begin
            j_d     = '0;
            state_d = S_OUT_R;
          end else begin
            k_d     = nm2[AW-1:0];
            ph_d    = PH_PASS_FK1;
            state_d = S_FK_R0;
          end
        end
      end
      S_FK_R0: begin
        if (k_q != '0) begin
          re = 1'b1;
          ra = k_q - AW'(1);
        end
        state_d = S_FK_R1;
      end
      S_FK_R1: begin
        gp_d    = (k_q != '0) ? r_glb : '0;
        re      = 1'b1;
        ra      = k_q;
        first_d = 1'b1;
        state_d = S_FK_M;
      end
      S_FK_M: begin
        g_calc = gp_q + r_loc;
        ent    = rent;
        ent[GLB_LO +: A] = g_calc;
        if (!first_q) begin
          ent[X_LO +: C] = px_q;
          ent[Y_LO +: C] = py_q;
        end
        we       = 1'b1;
        wa       = k_q;
        wd       = ent;
        e_d      = ent;
        gp_d     = g_calc;
        first_d  = 1'b0;
        cd_start = 1'b1;
        cd_rot   = 1'b1;
        cd_ang   = g_calc;
        state_d  = S_FK_CW;
      end
      S_FK_CW: begin
        if (cdone_q) begin
          prod_d  = PW'(mul_a * mul_b);
          state_d = S_FK_MX;
        end
      end
      S_FK_MX: begin
        px_d    = e_q[X_LO +: C] + rnd_off(prod_q);
        prod_d  = PW'(mul_a * mul_b);
        state_d = S_FK_MY;
      end
      S_FK_MY: begin
        py_new = e_q[Y_LO +: C] + rnd_off(prod_q);
        py_d   = py_new;
        if (({1'b0, k_q} + (AW + 1)'(1)) < n_q) begin
          k_d     = k_q + AW'(1);
          re      = 1'b1;
          ra      = k_q + AW'(1);
          state_d = S_FK_M;
        end else begin
          tipx_d = px_q;
          tipy_d = py_new;
          unique case (ph_q)
            PH_PASS_FK1: begin
              if (n_q > (AW + 1)'(2)) begin
                i_d     = nm2[AW-1:0];
                k_d     = nm2[AW-1:0] - AW'(1);
                ph_d    = PH_INNER_FK;
              end else begin
                k_d     = '0;
                ph_d    = PH_PASS_FK0;
              end
              state_d = S_FK_R0;
            end
            PH_INNER_FK: state_d = S_UP_R1;
            PH_PASS_FK0: state_d = S_RT;
            PH_FINAL_FK: begin
              fin_d   = 1'b1;
              state_d = S_AL_R1;
            end
            default: state_d = S_IDLE;
          endcase
        end
      end
      S_UP_R1: begin
        re      = 1'b1;
        ra      = i_q;
        state_d = S_UP_R2;
      end
      S_UP_R2: begin
        e_d      = rent;
        re       = 1'b1;
        ra       = i_q - AW'(1);
        cd_start = 1'b1;
        cd_ax    = $signed({tipx_q[C-1], tipx_q}) - $signed({r_x[C-1], r_x});
        cd_ay    = $signed({tipy_q[C-1], tipy_q}) - $signed({r_y[C-1], r_y});
        state_d  = S_UP_CW1;
      end
      S_UP_CW1: begin
        if (cdone_q) begin
          cur_d    = ang;
          cd_start = 1'b1;
          cd_ax    = $signed({tx_q[C-1], tx_q}) -
                     $signed({e_q[X_LO + C - 1], e_q[X_LO +: C]});
          cd_ay    = $signed({ty_q[C-1], ty_q}) -
                     $signed({e_q[Y_LO + C - 1], e_q[Y_LO +: C]});
          state_d  = S_UP_CW2;
        end
      end
      S_UP_CW2: begin
        if (cdone_q) begin
          g_calc = e_q[GLB_LO +: A] - (cur_q - ang);
          we     = 1'b1;
          wa     = i_q;
          wd     = e_q;
          wd[GLB_LO +: A] = g_calc;
          wd[LOC_LO +: A] = g_calc - r_glb;
          if (i_q > AW'(1)) begin
            i_d  = i_q - AW'(1);
            k_d  = i_q - AW'(2);
            ph_d = PH_INNER_FK;
          end else begin
            k_d  = '0;
            ph_d = PH_PASS_FK0;
          end
          state_d = S_FK_R0;
        end
      end
      S_RT: begin
        re       = 1'b1;
        ra       = '0;
        cd_start = 1'b1;
        cd_ax    = $signed({tipx_q[C-1], tipx_q});
        cd_ay    = $signed({tipy_q[C-1], tipy_q});
        state_d  = S_RT_CW1;
      end
      S_RT_CW1: begin
        if (cdone_q) begin
          cur_d    = ang;
          cd_start = 1'b1;
          cd_ax    = $signed({tx_q[C-1], tx_q});
          cd_ay    = $signed({ty_q[C-1], ty_q});
          state_d  = S_RT_CW2;
        end
      end
      S_RT_CW2: begin
        if (cdone_q) begin
          we = 1'b1;
          wa = '0;
          wd = rent;
          wd[LOC_LO +: A] = r_loc - (cur_q - ang);
          pass_d = pass_q + 8'd1;
          if ((pass_q + 8'd1) < iters_q) begin
            fin_d   = 1'b0;
            state_d = S_AL_R1;
          end else begin
            k_d     = '0;
            ph_d    = PH_FINAL_FK;
            state_d = S_FK_R0;
          end
        end
      end
      S_OUT_R: begin
        re      = 1'b1;
        ra      = j_q;
        state_d = S_OUT_E;
      end
      S_OUT_E: begin
        out_stb_d  = 1'b1;
        out_last_d = ({1'b0, j_q} == nm1);
        if ({1'b0, j_q} < nm1) begin
          j_d = j_q + AW'(1);
          re  = 1'b1;
          ra  = j_q + AW'(1);
        end else begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      ph_q          <= PH_PASS_FK1;
      joint_count_q <= 4'd2;
      fin_q         <= 1'b0;
      first_q       <= 1'b0;
      n_q           <= (AW + 1)'(2);
      k_q           <= '0;
      i_q           <= '0;
      j_q           <= '0;
      pass_q        <= '0;
      iters_q       <= '0;
      tipx_q        <= '0;
      tipy_q        <= '0;
      strobe_o      <= 1'b0;
    end else begin
      state_q  <= state_d;
      ph_q     <= ph_d;
      fin_q    <= fin_d;
      first_q  <= first_d;
      n_q      <= n_d;
      k_q      <= k_d;
      i_q      <= i_d;
      j_q      <= j_d;
      pass_q   <= pass_d;
      iters_q  <= iters_d;
      tipx_q   <= tipx_d;
      tipy_q   <= tipy_d;
      strobe_o <= out_stb_d;
      if (cfg_we_i) begin
        joint_count_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    gp_q     <= gp_d;
    cur_q    <= cur_d;
    e_q      <= e_d;
    px_q     <= px_d;
    py_q     <= py_d;
    tx_q     <= tx_d;
    ty_q     <= ty_d;
    ld_len_q <= ld_len_d;
    prod_q   <= prod_d;
    if (out_stb_d) begin
      joint_number_o <= out_num_d;
      local_angle_o  <= r_loc;
      joint_x_o      <= r_x;
      joint_y_o      <= r_y;
      last_o         <= out_last_d;
    end
  end

  assign busy = (state_q != S_IDLE);

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && command_i == CMD_SOLVE |=> busy)
    else $error("solve item accepted but block not busy");

  a_cordic_idle_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cd_start |-> !crun_q)
    else $error("CORDIC restarted while running");

  a_write_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    we |-> (32'(wa) < 32'(MAX_JOINTS)))
    else $error("joint memory write beyond depth");

  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o && last_o |=> !strobe_o)
    else $error("result after the final joint");

  a_strobe_from_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o |-> $past(state_q == S_OUT_E))
    else $error("result strobe outside output sequence");

endmodule

// File: bench/planar_arm_ccd_ik_solver_tb.sv
// ---------------------------------------------------------------------------
// Planar arm solver testbench
// Drives load and solve items with random gaps, predicts every joint result
// with an independent fixed-point model of the descent and checks each one.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module planar_arm_ccd_ik_solver_tb;
  import paik_pkg::*;

  localparam int NJ = 8;
  localparam longint CYCLE_LIMIT = 4000000;

  typedef struct {
    bit [2:0]  joint;
    bit [15:0] angle;
    bit [23:0] jx;
    bit [23:0] jy;
    bit        last;
  } joint_res_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [3:0] cfg_wdata_i = '0;
  logic start = 1'b0;
  logic busy;
  logic command_i = CMD_LOAD;
  logic [2:0] joint_index_i = '0;
  logic [15:0] link_length_i = '0;
  logic signed [23:0] target_x_i = '0;
  logic signed [23:0] target_y_i = '0;
  logic [7:0] iterations_i = '0;
  logic strobe_o;
  logic [2:0] joint_number_o;
  logic signed [15:0] local_angle_o;
  logic signed [23:0] joint_x_o;
  logic signed [23:0] joint_y_o;
  logic last_o;

  planar_arm_ccd_ik_solver u_top (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_we_i), .cfg_wdata_i(cfg_wdata_i),
    .start(start), .busy(busy), .command_i(command_i), .joint_index_i(joint_index_i),
    .link_length_i(link_length_i), .target_x_i(target_x_i), .target_y_i(target_y_i),
    .iterations_i(iterations_i), .strobe_o(strobe_o), .joint_number_o(joint_number_o),
    .local_angle_o(local_angle_o), .joint_x_o(joint_x_o), .joint_y_o(joint_y_o),
    .last_o(last_o)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // Arm state of the predictor.
  bit [3:0]  arm_count;
  bit [15:0] arm_len [NJ];
  bit [15:0] arm_local [NJ];
  bit [15:0] arm_global [NJ];
  longint    arm_px [NJ];
  longint    arm_py [NJ];
  longint    arm_tipx;
  longint    arm_tipy;

  joint_res_t pending_joints [$];
  int errors = 0;
  longint cycles = 0;

  const bit [31:0] rot_step [30] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
    32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
    32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001
  };

  function automatic longint wrap24(longint v);
    logic signed [23:0] t;
    t = v[23:0];
    return longint'(t);
  endfunction

  function automatic void rotate(bit [15:0] ang, output longint s, output longint c);
    longint z, x, y, dx, dy;
    bit flip;
    z = longint'({ang, 16'h0000});
    x = 652032874;
    y = 0;
    flip = 1'b0;
    if (z >= 64'sd2147483648) z -= 64'sd4294967296;
    if (z > 64'sd1073741824) begin
      z -= 64'sd2147483648;
      flip = 1'b1;
    end else if (z < -64'sd1073741824) begin
      z += 64'sd2147483648;
      flip = 1'b1;
    end
    for (int i = 0; i < 30; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= longint'(rot_step[i]);
      end else begin
        x += dx; y -= dy; z += longint'(rot_step[i]);
      end
    end
    if (flip) begin
      x = -x; y = -y;
    end
    s = y;
    c = x;
  endfunction

  function automatic longint scaled(bit [15:0] len, longint f);
    return (longint'(len) * f + 64'sd536870912) >>> 30;
  endfunction

  function automatic bit [15:0] heading(longint ax, longint ay);
    longint vx, vy, z, dx, dy;
    bit [31:0] r;
    bit [31:0] base;
    if (ax == 0 && ay == 0) return 16'h0000;
    vx = ay * 64'sd1048576;
    vy = ax * 64'sd1048576;
    z = 0;
    base = 32'h0;
    if (vx < 0) begin
      vx = -vx; vy = -vy; base = 32'h80000000;
    end
    for (int i = 0; i < 30; i++) begin
      dx = vy >>> i;
      dy = vx >>> i;
      if (vy > 0) begin
        vx += dx; vy -= dy; z += longint'(rot_step[i]);
      end else begin
        vx -= dx; vy += dy; z -= longint'(rot_step[i]);
      end
    end
    r = base + z[31:0];
    r = r + 32'h00008000;
    return r[31:16];
  endfunction

  function automatic void chain_forward(int from, int n);
    longint s, c;
    arm_global[from] = (from > 0 ? arm_global[from-1] : 16'h0) + arm_local[from];
    for (int i = from + 1; i < n; i++) begin
      arm_global[i] = arm_global[i-1] + arm_local[i];
      rotate(arm_global[i-1], s, c);
      arm_px[i] = wrap24(arm_px[i-1] + scaled(arm_len[i-1], s));
      arm_py[i] = wrap24(arm_py[i-1] + scaled(arm_len[i-1], c));
    end
    rotate(arm_global[n-1], s, c);
    arm_tipx = wrap24(arm_px[n-1] + scaled(arm_len[n-1], s));
    arm_tipy = wrap24(arm_py[n-1] + scaled(arm_len[n-1], c));
  endfunction

  function automatic void point_last(int n, longint tx, longint ty);
    arm_local[n-1] = heading(tx - arm_px[n-1], ty - arm_py[n-1]) - arm_global[n-2];
  endfunction

  function automatic void arm_clear();
    arm_count = 4'd2;
    for (int i = 0; i < NJ; i++) begin
      arm_len[i] = '0; arm_local[i] = '0; arm_global[i] = '0;
      arm_px[i] = 0; arm_py[i] = 0;
    end
    arm_tipx = 0;
    arm_tipy = 0;
  endfunction

  function automatic void solve_arm(bit [23:0] tgx, bit [23:0] tgy, bit [7:0] passes);
    int n;
    longint tx, ty;
    bit [15:0] cur, tgt;
    joint_res_t r;
    n = arm_count < 2 ? 2 : (arm_count > NJ ? NJ : arm_count);
    tx = wrap24(longint'(tgx));
    ty = wrap24(longint'(tgy));
    for (int p = 0; p < passes; p++) begin
      point_last(n, tx, ty);
      chain_forward(n - 2, n);
      for (int i = n - 2; i > 0; i--) begin
        chain_forward(i - 1, n);
        cur = heading(arm_tipx - arm_px[i], arm_tipy - arm_py[i]);
        tgt = heading(tx - arm_px[i], ty - arm_py[i]);
        arm_global[i] = arm_global[i] - (cur - tgt);
        arm_local[i] = arm_global[i] - arm_global[i-1];
      end
      chain_forward(0, n);
      cur = heading(arm_tipx, arm_tipy);
      tgt = heading(tx, ty);
      arm_local[0] = arm_local[0] - (cur - tgt);
    end
    chain_forward(0, n);
    point_last(n, tx, ty);
    for (int j = 0; j < n; j++) begin
      r.joint = j[2:0];
      r.angle = arm_local[j];
      r.jx = arm_px[j][23:0];
      r.jy = arm_py[j][23:0];
      r.last = (j == n - 1);
      pending_joints = {pending_joints, r};
    end
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("%0t: %s got %0h expected %0h", $realtime, what, got, want);
    errors++;
  endtask

  always @(negedge clk_i) begin
    joint_res_t e;
    if (rst_ni && strobe_o === 1'b1) begin
      if (pending_joints.size() == 0) begin
        report_mismatch("unexpected result, joint", joint_number_o, 0);
      end else begin
        e = pending_joints.pop_front();
        if (joint_number_o !== e.joint) report_mismatch("joint_number", joint_number_o, e.joint);
        if (local_angle_o !== e.angle) report_mismatch("local_angle", local_angle_o, e.angle);
        if (joint_x_o !== e.jx) report_mismatch("joint_x", joint_x_o, e.jx);
        if (joint_y_o !== e.jy) report_mismatch("joint_y", joint_y_o, e.jy);
        if (last_o !== e.last) report_mismatch("last", last_o, e.last);
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("planar_arm_ccd_ik_solver: mismatch");
      $finish;
    end
  end

  int burst_left = 0;

  task automatic send_item(bit cmd, bit [2:0] idx, bit [15:0] len,
                           bit [23:0] tx, bit [23:0] ty, bit [7:0] passes);
    bit taken;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 6);
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    burst_left--;
    start <= 1'b1;
    command_i <= cmd;
    joint_index_i <= idx;
    link_length_i <= len;
    target_x_i <= tx;
    target_y_i <= ty;
    iterations_i <= passes;
    do begin
      @(negedge clk_i);
      taken = (busy === 1'b0);
      @(posedge clk_i);
    end while (!taken);
    if (cmd == CMD_LOAD) arm_len[idx] = len;
    else solve_arm(tx, ty, passes);
    if (burst_left == 0) start <= 1'b0;
  endtask

  task automatic settle();
    if (burst_left != 0) start <= 1'b0;
    burst_left = 0;
    wait (pending_joints.size() == 0);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic write_count(bit [3:0] v);
    settle();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    arm_count = v;
    @(posedge clk_i);
  endtask

  task automatic test_directed();
    send_item(CMD_SOLVE, 3'd0, 16'h0, 24'h0, 24'h0, 8'd0);
    send_item(CMD_SOLVE, 3'd0, 16'h0, 24'h0, 24'h0, 8'd2);
    send_item(CMD_LOAD, 3'd0, 16'h0A00, 24'h0, 24'h0, 8'd0);
    send_item(CMD_LOAD, 3'd1, 16'hFFFF, 24'h0, 24'h0, 8'd0);
    send_item(CMD_LOAD, 3'd7, 16'h0300, 24'h0, 24'h0, 8'd0);
    send_item(CMD_SOLVE, 3'd7, 16'hFFFF, 24'h7FFFFF, 24'h7FFFFF, 8'd1);
    send_item(CMD_SOLVE, 3'd0, 16'h0, 24'h800000, 24'h800000, 8'd1);
    send_item(CMD_SOLVE, 3'd0, 16'h0, 24'h001400, 24'hFFF000, 8'd255);
    send_item(CMD_SOLVE, 3'd0, 16'h0, 24'hFFFFFF, 24'h000000, 8'd0);
    send_item(CMD_LOAD, 3'd1, 16'h0000, 24'h0, 24'h0, 8'd0);
    send_item(CMD_SOLVE, 3'd0, 16'h0, 24'h000500, 24'h000500, 8'd3);
  endtask

  task automatic test_joint_counts();
    bit [3:0] counts [6] = '{4'd8, 4'd0, 4'd15, 4'd1, 4'd9, 4'd3};
    foreach (counts[k]) begin
      write_count(counts[k]);
      for (int j = 0; j < NJ; j++)
        send_item(CMD_LOAD, j[2:0], 16'($urandom_range(16'h0100, 16'h1000)), 24'h0, 24'h0, 8'd0);
      send_item(CMD_SOLVE, 3'd0, 16'h0, 24'h002000, 24'hFFE000, 8'd2);
    end
  endtask

  task automatic test_random();
    bit [23:0] tx, ty;
    bit [7:0] passes;
    for (int ph = 0; ph < 7; ph++) begin
      write_count(ph == 6 ? 4'd8 : 4'($urandom_range(0, 15)));
      for (int k = 0; k < 11; k++) begin
        if ($urandom_range(0, 99) < 40) begin
          send_item(CMD_LOAD, 3'($urandom), $urandom_range(0, 3) == 0 ? 16'($urandom)
                    : 16'($urandom_range(0, 16'h0FFF)), 24'($urandom), 24'($urandom),
                    8'($urandom));
        end else begin
          if ($urandom_range(0, 3) == 0) begin
            tx = 24'($urandom); ty = 24'($urandom);
          end else begin
            tx = 24'($signed(20'($urandom)));
            ty = 24'($signed(20'($urandom)));
          end
          passes = $urandom_range(0, 9) == 0 ? 8'($urandom_range(3, 6))
                   : 8'($urandom_range(0, 2));
          send_item(CMD_SOLVE, 3'($urandom), 16'($urandom), tx, ty, passes);
        end
      end
    end
  endtask

  initial begin
    arm_clear();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_joint_counts();
    test_random();
    settle();
    repeat (100) @(posedge clk_i);
    if (errors == 0 && pending_joints.size() == 0) begin
      $display("planar_arm_ccd_ik_solver: match");
    end else begin
      $display("planar_arm_ccd_ik_solver: mismatch");
    end
    $finish;
  end

endmodule

// File: planar_arm_ccd_ik_solver.f
hdl/paik_pkg.sv
hdl/planar_arm_ccd_ik_solver.sv
bench/planar_arm_ccd_ik_solver_tb.sv
